/* rtl/core/mfe_pkg.sv */
package mfe_pkg;

    // Defaults for the top-level parameters.
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int COUNT_WIDTH_DEF    = 24;
    localparam int FREQ_FRAC_BITS_DEF = 16;

    // Fixed field widths.
    localparam int FREQ_INT_BITS = 8;
    localparam int RATE_W        = 27;
    localparam int THRESH_W      = 16;
    localparam int ALPHA_W       = 17;
    localparam int OUT_FREQ_W    = 24;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 27;

    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESHOLD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_THRESHOLD = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ALPHA          = 3'd3;

    // Register reset values.
    localparam logic [RATE_W-1:0]          RATE_RESET        = 27'd10000;
    localparam logic signed [THRESH_W-1:0] LOW_THRESH_RESET  = -16'sd1024;
    localparam logic signed [THRESH_W-1:0] HIGH_THRESH_RESET = 16'sd1024;
    localparam logic [ALPHA_W-1:0]         ALPHA_RESET       = 17'd459;

    // Alpha is unsigned Q1.16, so unity weight is 2^16.
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam int                 ALPHA_SHIFT = 16;

    // The average starts at 25 Hz.
    localparam int AVG_RESET_HZ = 25;

endpackage

/* rtl/core/mfe_sample_if.sv */
interface mfe_sample_if #(
    parameter int SAMPLE_WIDTH = mfe_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

/* rtl/core/mfe_result_if.sv */
interface mfe_result_if;
    import mfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [OUT_FREQ_W-1:0] frequency_average;
    logic                  level_high;
    logic                  half_period_done;

    modport source (
        output valid, output frequency_average, output level_high,
        output half_period_done, input ready
    );
    modport sink (
        input valid, input frequency_average, input level_high,
        input half_period_done, output ready
    );
endinterface

/* rtl/core/mfe_cfg_if.sv */
interface mfe_cfg_if;
    import mfe_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/core/mains_frequency_estimator.sv */
// Mains frequency estimator.
// The samples channel takes one signed converter word per handshake. The
// results channel returns one word per sample: the averaged frequency in
// unsigned Q8.16 Hz, the hysteresis level and a flag for an ended half
// period. The cfg channel writes the sample rate, both thresholds and the
// averaging weight; it is always ready and should be used while idle.
// A sample that does not end a half period puts its word straight into the
// output register, or the block holds the word if that register is occupied.
// A sample that ends a half period with a nonzero count passes through the
// divide, round, multiply and average states: the rate-over-count quotient
// is formed one bit per cycle by a restoring divider, then the weighted
// update is formed one alpha bit per cycle by a shift-and-add multiplier.
// The result register decouples the two sides: a new sample is taken while
// a word still waits; if a second word is ready before the first is taken,
// the block holds it and stops taking samples until the output drains.
// Reset clears the level and both counters, loads the default configuration
// and sets the average to 25 Hz.
module mains_frequency_estimator #(
    parameter int SAMPLE_WIDTH   = mfe_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH    = mfe_pkg::COUNT_WIDTH_DEF,
    parameter int FREQ_FRAC_BITS = mfe_pkg::FREQ_FRAC_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    mfe_cfg_if.sink      cfg,
    mfe_sample_if.sink   samples,
    mfe_result_if.source results
);
    import mfe_pkg::*;

    localparam int FREQ_W    = FREQ_INT_BITS + FREQ_FRAC_BITS;
    localparam int CMP_W     = (SAMPLE_WIDTH > THRESH_W) ? SAMPLE_WIDTH : THRESH_W;
    localparam int DIV_STEPS = RATE_W + FREQ_FRAC_BITS;
    localparam int MUL_STEPS = ALPHA_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int REM_W     = COUNT_WIDTH + 1;
    localparam int HI_W      = FREQ_W + 3;
    localparam int PROD_W    = HI_W + ALPHA_W;

    localparam logic [FREQ_W-1:0]      AVG_RESET  = FREQ_W'(AVG_RESET_HZ) << FREQ_FRAC_BITS;
    localparam logic signed [HI_W-1:0] ROUND_BIAS = HI_W'(2 ** (ALPHA_SHIFT - 1));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_AVG   = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;

    function automatic logic [COUNT_WIDTH-1:0] count_up(input logic [COUNT_WIDTH-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    // Configuration registers.
    logic [RATE_W-1:0]          rate_reg;
    logic signed [THRESH_W-1:0] low_thresh_reg;
    logic signed [THRESH_W-1:0] high_thresh_reg;
    logic [ALPHA_W-1:0]         alpha_reg;

    // Control state.
    logic [2:0]             state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   level_reg, level_next;
    logic [COUNT_WIDTH-1:0] low_count_reg, low_count_next;
    logic [COUNT_WIDTH-1:0] high_count_reg, high_count_next;
    logic [FREQ_W-1:0]      avg_reg, avg_next;
    logic                   out_valid_reg, out_valid_next;

    // Datapath registers.
    logic                    done_reg, done_next;
    logic [COUNT_WIDTH-1:0]  div_count_reg, div_count_next;
    logic [DIV_STEPS-1:0]    dividend_reg, dividend_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [FREQ_W-1:0]       quot_reg, quot_next;
    logic                    quot_ovf_reg, quot_ovf_next;
    logic signed [FREQ_W:0]  mcand_reg, mcand_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [OUT_FREQ_W-1:0]   out_freq_reg, out_freq_next;
    logic                    out_level_reg, out_level_next;
    logic                    out_done_reg, out_done_next;

    // Handshakes.
    logic accept;
    logic out_free;

    assign cfg.ready     = 1'b1;
    assign samples.ready = (state_reg == S_IDLE);
    assign accept        = samples.valid && samples.ready;
    assign out_free      = !out_valid_reg || results.ready;

    assign results.valid             = out_valid_reg;
    assign results.frequency_average = out_freq_reg;
    assign results.level_high        = out_level_reg;
    assign results.half_period_done  = out_done_reg;

    // Hysteresis comparator and half-period counters.
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic signed [CMP_W-1:0]        s_ext, lo_ext, hi_ext;
    logic                           above, below, between;
    logic                           crossing;
    logic [COUNT_WIDTH-1:0]         finish_count;
    logic [COUNT_WIDTH-1:0]         hyst_low_count, hyst_high_count;
    logic                           hyst_level;
    logic                           start_div;

    assign sample_in = samples.sample;
    assign s_ext     = CMP_W'(sample_in);
    assign lo_ext    = CMP_W'(low_thresh_reg);
    assign hi_ext    = CMP_W'(high_thresh_reg);
    assign above     = s_ext > hi_ext;
    assign below     = s_ext < lo_ext;
    assign between   = (s_ext > lo_ext) && (s_ext < hi_ext);

    always_comb
    begin
        hyst_level      = level_reg;
        hyst_low_count  = low_count_reg;
        hyst_high_count = high_count_reg;
        crossing        = 1'b0;
        finish_count    = low_count_reg;
        if (above && !level_reg)
        begin
            crossing        = 1'b1;
            finish_count    = low_count_reg;
            hyst_low_count  = '0;
            hyst_level      = 1'b1;
            hyst_high_count = count_up(high_count_reg);
        end
        else if ((above || between) && level_reg)
        begin
            hyst_high_count = count_up(high_count_reg);
        end
        else if (below && level_reg)
        begin
            crossing        = 1'b1;
            finish_count    = high_count_reg;
            hyst_high_count = '0;
            hyst_level      = 1'b0;
            hyst_low_count  = count_up(low_count_reg);
        end
        else if ((below || between) && !level_reg)
        begin
            hyst_low_count = count_up(low_count_reg);
        end
    end

    assign start_div = crossing && (finish_count != '0);

    // One restoring division step: rate * 2^F over twice the count.
    logic [REM_W:0]   rem_shift;
    logic [REM_W:0]   divisor_ext;
    logic             rem_ge;
    logic [REM_W-1:0] rem_step;

    assign rem_shift   = {rem_reg, dividend_reg[DIV_STEPS-1]};
    assign divisor_ext = {1'b0, div_count_reg, 1'b0};
    assign rem_ge      = rem_shift >= divisor_ext;
    assign rem_step    = rem_ge ? REM_W'(rem_shift - divisor_ext) : rem_shift[REM_W-1:0];

    // Round to nearest: the sum gains one when the remainder reaches the count.
    logic              round_up;
    logic [FREQ_W:0]   quot_sum;
    logic [FREQ_W-1:0] freq_sat;
    logic [ALPHA_W-1:0] alpha_eff;

    assign round_up  = rem_reg >= {1'b0, div_count_reg};
    assign quot_sum  = {1'b0, quot_reg} + (FREQ_W + 1)'(round_up);
    assign freq_sat  = (quot_ovf_reg || quot_sum[FREQ_W]) ? '1 : quot_sum[FREQ_W-1:0];
    assign alpha_eff = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;

    // One shift-and-add step of alpha times (f - avg), rounding bias preloaded.
    logic signed [HI_W-1:0] prod_hi;
    logic signed [HI_W-1:0] hi_sum;
    logic [PROD_W-1:0]      prod_step;

    assign prod_hi   = prod_reg[PROD_W-1:ALPHA_W];
    assign hi_sum    = prod_reg[0] ? prod_hi + HI_W'(mcand_reg) : prod_hi;
    assign prod_step = {hi_sum[HI_W-1], hi_sum, prod_reg[ALPHA_W-1:1]};

    // New average: old value plus the rounded, scaled product.
    logic signed [HI_W:0] avg_delta;
    logic signed [HI_W:0] avg_sum;
    logic [FREQ_W-1:0]    avg_new;

    assign avg_delta = prod_reg[PROD_W-1:ALPHA_SHIFT];
    assign avg_sum   = avg_delta + $signed({{(HI_W + 1 - FREQ_W){1'b0}}, avg_reg});
    assign avg_new   = avg_sum[FREQ_W-1:0];

    // Result word source for this cycle.
    logic              emit;
    logic [FREQ_W-1:0] emit_freq;
    logic              emit_level;
    logic              emit_done;

    always_comb
    begin
        emit       = 1'b0;
        emit_freq  = avg_reg;
        emit_level = level_reg;
        emit_done  = done_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                emit       = accept && !start_div;
                emit_level = hyst_level;
                emit_done  = 1'b0;
            end
            S_AVG:
            begin
                emit      = 1'b1;
                emit_freq = avg_new;
                emit_done = 1'b1;
            end
            S_WAIT:
            begin
                emit = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer and next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        level_next      = level_reg;
        low_count_next  = low_count_reg;
        high_count_next = high_count_reg;
        avg_next        = avg_reg;
        done_next       = done_reg;
        div_count_next  = div_count_reg;
        dividend_next   = dividend_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        quot_ovf_next   = quot_ovf_reg;
        mcand_next      = mcand_reg;
        prod_next       = prod_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    level_next      = hyst_level;
                    low_count_next  = hyst_low_count;
                    high_count_next = hyst_high_count;
                    done_next       = 1'b0;
                    if (start_div)
                    begin
                        div_count_next = finish_count;
                        dividend_next  = {rate_reg, {FREQ_FRAC_BITS{1'b0}}};
                        rem_next       = '0;
                        quot_next      = '0;
                        quot_ovf_next  = 1'b0;
                        step_next      = '0;
                        state_next     = S_DIV;
                    end
                    else if (!out_free)
                    begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_DIV:
            begin
                dividend_next = {dividend_reg[DIV_STEPS-2:0], 1'b0};
                rem_next      = rem_step;
                quot_next     = {quot_reg[FREQ_W-2:0], rem_ge};
                quot_ovf_next = quot_ovf_reg || quot_reg[FREQ_W-1];
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                mcand_next = $signed({1'b0, freq_sat}) - $signed({1'b0, avg_reg});
                prod_next  = {ROUND_BIAS, alpha_eff};
                step_next  = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = prod_step;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MUL_STEPS - 1))
                begin
                    state_next = S_AVG;
                end
            end
            S_AVG:
            begin
                avg_next   = avg_new;
                done_next  = 1'b1;
                state_next = out_free ? S_IDLE : S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_freq_next  = out_freq_reg;
        out_level_next = out_level_reg;
        out_done_next  = out_done_reg;
        if (emit && out_free)
        begin
            out_valid_next = 1'b1;
            out_freq_next  = OUT_FREQ_W'(emit_freq);
            out_level_next = emit_level;
            out_done_next  = emit_done;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg        <= RATE_RESET;
            low_thresh_reg  <= LOW_THRESH_RESET;
            high_thresh_reg <= HIGH_THRESH_RESET;
            alpha_reg       <= ALPHA_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SAMPLE_RATE:    rate_reg        <= cfg.data[RATE_W-1:0];
                REG_LOW_THRESHOLD:  low_thresh_reg  <= cfg.data[THRESH_W-1:0];
                REG_HIGH_THRESHOLD: high_thresh_reg <= cfg.data[THRESH_W-1:0];
                REG_ALPHA:          alpha_reg       <= cfg.data[ALPHA_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= '0;
            level_reg      <= 1'b0;
            low_count_reg  <= '0;
            high_count_reg <= '0;
            avg_reg        <= AVG_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            step_reg       <= step_next;
            level_reg      <= level_next;
            low_count_reg  <= low_count_next;
            high_count_reg <= high_count_next;
            avg_reg        <= avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath and payload registers.
    always_ff @(posedge clk)
    begin
        done_reg      <= done_next;
        div_count_reg <= div_count_next;
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        quot_reg      <= quot_next;
        quot_ovf_reg  <= quot_ovf_next;
        mcand_reg     <= mcand_next;
        prod_reg      <= prod_next;
        out_freq_reg  <= out_freq_next;
        out_level_reg <= out_level_next;
        out_done_reg  <= out_done_next;
    end

    // The divider only runs on a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_count_reg != '0))
        else $error("divider running with a zero count");

    // The partial remainder always stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < {div_count_reg, 1'b0}))
        else $error("divider remainder not below divisor");

    // A held word means the output register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WAIT) |-> out_valid_reg)
        else $error("held word with an empty output register");

    // The iteration counter never runs past the divider length.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV || state_reg == S_MUL) |-> (step_reg < STEP_W'(DIV_STEPS)))
        else $error("iteration counter out of range");

    // Each ended half period updates the average right after the multiplier.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && step_reg == STEP_W'(MUL_STEPS - 1)) |=> (state_reg == S_AVG))
        else $error("multiplier did not hand over to the average update");

endmodule
